// ===== design/range_scan_cluster_centroids_core_defines.svh =====
// Assertion macros used by the checker module of the scan clustering core.
`ifndef RANGE_SCAN_CLUSTER_CENTROIDS_CORE_DEFINES_SVH
`define RANGE_SCAN_CLUSTER_CENTROIDS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rscc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rscc assertion failed");

`endif

// ===== design/rscc_pkg.sv =====
// Shared types, constants and tables of the scan clustering core.
package rscc_pkg;

    localparam int SCAN_MAX_DEF   = 2048;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_W       = 34;
    localparam int ADDR_W         = 5;
    localparam int CMD_DEPTH      = 4;
    localparam int RES_DEPTH      = 4;
    localparam int COORD_W        = 17;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_MIN_MM,
        REG_MAX_MM,
        REG_GAP,
        REG_ARC,
        REG_SCAN_LEN,
        REG_ANGLE_START,
        REG_ANGLE_STEP
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        min_mm;
        logic [15:0]        max_mm;
        logic [15:0]        gap;
        logic [7:0]         arc;
        logic [11:0]        scan_len;
        logic signed [15:0] angle_start;
        logic [15:0]        angle_step;
    } t_cfg;

    typedef struct packed {
        logic        pre;
        logic        add;
        logic        post;
        logic [15:0] range;
        logic [15:0] angle;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_CORDIC,
        ST_TRIG,
        ST_MUL,
        ST_ACC,
        ST_FLUSH
    } t_back_state;

    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rscc_fifo.sv =====
// Small register queue used for the command and result buffers.
module rscc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/rscc_front.sv =====
// Front end: classifies each sample and issues close, add and flush commands.
module rscc_front #(
    parameter int SCAN_MAX = rscc_pkg::SCAN_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rscc_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic [15:0]   i_range_mm,
    input  logic          i_range_infinite,
    input  logic          i_last_sample,
    output logic          o_cmd_push,
    output rscc_pkg::t_cmd o_cmd
);
    import rscc_pkg::*;

    localparam int IW = $clog2(SCAN_MAX);
    localparam int CW = IW + 1;

    logic [IW-1:0]      r_index;
    logic [15:0]        r_prev_range;
    logic               r_prev_valid;
    logic [CW-1:0]      r_size;

    logic               sample_ok, in_arc, join_ok, active, add, pre, post;
    logic signed [9:0]  arc_diff, m;
    logic signed [31:0] lhs, len, m_ext, lo, hi;
    logic [15:0]        rdiff;
    logic [CW-1:0]      size1, size_add, size_next;

    always_comb begin
        sample_ok = !i_range_infinite && (i_range_mm > i_cfg.min_mm)
                    && (i_range_mm < i_cfg.max_mm);
        arc_diff  = 10'sd180 - signed'(10'(i_cfg.arc));
        m         = arc_diff[9] ? ((arc_diff + 10'sd1) >>> 1) : (arc_diff >>> 1);
        lhs       = signed'(32'(r_index) * 32'd180);
        len       = signed'(32'(i_cfg.scan_len));
        m_ext     = 32'(m);
        lo        = len * m_ext;
        hi        = len * (32'sd180 - m_ext);
        in_arc    = (lhs > lo) && (lhs < hi);
        rdiff     = (i_range_mm > r_prev_range) ? (i_range_mm - r_prev_range)
                                                : (r_prev_range - i_range_mm);
        join_ok   = (!r_prev_valid || (rdiff < i_cfg.gap)) && (r_size < CW'(SCAN_MAX));
        active    = (r_index != '0);
        add       = active && sample_ok && in_arc;
        pre       = active && (!add || !join_ok) && (r_size != '0);
        size1     = pre ? '0 : r_size;
        size_add  = size1 + CW'(add);
        post      = i_last_sample && (size_add != '0);
        size_next = post ? '0 : size_add;
    end

    assign o_cmd_push  = i_accept && (pre || add || post);
    assign o_cmd.pre   = pre;
    assign o_cmd.add   = add;
    assign o_cmd.post  = post;
    assign o_cmd.range = i_range_mm;
    assign o_cmd.angle = i_cfg.angle_start + 16'(i_cfg.angle_step * 16'(r_index));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_prev_range <= '0;
            r_prev_valid <= 1'b0;
            r_size       <= '0;
        end else if (i_accept) begin
            if (i_last_sample) begin
                r_index <= '0;
            end else if (r_index != IW'(SCAN_MAX - 1)) begin
                r_index <= r_index + 1'b1;
            end
            r_prev_range <= i_range_mm;
            r_prev_valid <= sample_ok;
            r_size       <= size_next;
        end
    end

endmodule

// ===== design/rscc_back.sv =====
// Back end: CORDIC point conversion, cluster sums and centroid division.
module rscc_back #(
    parameter int SCAN_MAX = rscc_pkg::SCAN_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_empty,
    input  rscc_pkg::t_cmd           i_cmd,
    output logic                     o_cmd_pop,
    input  logic                     i_res_full,
    output logic                     o_res_push,
    output logic [rscc_pkg::COORD_W-1:0] o_x,
    output logic [rscc_pkg::COORD_W-1:0] o_y,
    output logic [$clog2(SCAN_MAX):0] o_count,
    output logic                     o_last
);
    import rscc_pkg::*;

    localparam int IW       = $clog2(SCAN_MAX);
    localparam int CW       = IW + 1;
    localparam int SW       = COORD_W + IW;
    localparam int STEP_MAX = (SW > CORDIC_STEPS) ? SW : CORDIC_STEPS;
    localparam int STW      = $clog2(STEP_MAX);
    localparam int XW       = CORDIC_W;
    localparam int TSH      = 30 - TRIG_FRAC_BITS;
    localparam logic signed [XW-1:0] ONE    = XW'(1) <<< TRIG_FRAC_BITS;
    localparam logic signed [XW-1:0] HALF_T = XW'(1) <<< (TSH - 1);
    localparam logic signed [XW-1:0] HALF_P = XW'(1) <<< (TRIG_FRAC_BITS - 1);

    t_back_state           r_state, n_state;
    t_cmd                  r_cmd;
    logic                  r_phase_post, r_flip;
    logic [STW-1:0]        r_step;
    logic signed [SW-1:0]  r_sum_x, r_sum_y;
    logic [CW-1:0]         r_count, r_den;
    logic signed [XW-1:0]  r_cx, r_cy, r_cz;
    logic signed [COORD_W-1:0] r_cos, r_sin;
    logic signed [XW-1:0]  r_px, r_py;
    logic [SW-1:0]         r_qx, r_qy;
    logic [CW-1:0]         r_rx, r_ry;
    logic                  r_negx, r_negy;

    logic                  start_div, start_cordic;
    t_cmd                  src;
    logic [31:0]           a_turn;
    logic signed [XW-1:0]  sx, sy, at, nx, ny, nz, xf, yf, xr, yr, pxr, pyr;
    logic [CW:0]           tx, ty;
    logic                  gex, gey;
    logic [SW-1:0]         qx_s, qy_s;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.pre || !i_cmd.add) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_CORDIC;
                    end
                end
            end
            ST_DIV: begin
                if (r_step == STW'(SW - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    if (!r_phase_post && r_cmd.add) begin
                        n_state = ST_CORDIC;
                    end else if (!r_phase_post && r_cmd.post) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CORDIC: begin
                if (r_step == STW'(CORDIC_STEPS - 1)) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = ST_FLUSH;
            ST_FLUSH: n_state = r_cmd.post ? ST_DIV : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        start_div    = 1'b0;
        start_cordic = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop    = 1'b1;
                    start_div    = i_cmd.pre || !i_cmd.add;
                    start_cordic = !i_cmd.pre && i_cmd.add;
                end
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    start_cordic = !r_phase_post && r_cmd.add;
                    start_div    = !r_phase_post && !r_cmd.add && r_cmd.post;
                end
            end
            ST_FLUSH: start_div = r_cmd.post;
            default: ;
        endcase
    end

    always_comb begin
        src    = (r_state == ST_IDLE) ? i_cmd : r_cmd;
        a_turn = {src.angle, 16'h0000};
        if (src.angle[15] ^ src.angle[14]) begin
            a_turn = a_turn ^ 32'h8000_0000;
        end
        sx = r_cx >>> r_step;
        sy = r_cy >>> r_step;
        at = signed'(XW'(atan_turn(r_step[4:0])));
        if (!r_cz[XW-1]) begin
            nx = r_cx - sy;
            ny = r_cy + sx;
            nz = r_cz - at;
        end else begin
            nx = r_cx + sy;
            ny = r_cy - sx;
            nz = r_cz + at;
        end
        xf  = r_flip ? -r_cx : r_cx;
        yf  = r_flip ? -r_cy : r_cy;
        xr  = (xf + HALF_T) >>> TSH;
        yr  = (yf + HALF_T) >>> TSH;
        if (xr > ONE) xr = ONE;
        if (xr < -ONE) xr = -ONE;
        if (yr > ONE) yr = ONE;
        if (yr < -ONE) yr = -ONE;
        pxr = (r_px + HALF_P) >>> TRIG_FRAC_BITS;
        pyr = (r_py + HALF_P) >>> TRIG_FRAC_BITS;
        tx  = {r_rx, r_qx[SW-1]};
        ty  = {r_ry, r_qy[SW-1]};
        gex = (tx >= {1'b0, r_den});
        gey = (ty >= {1'b0, r_den});
        qx_s = r_negx ? (~r_qx + 1'b1) : r_qx;
        qy_s = r_negy ? (~r_qy + 1'b1) : r_qy;
    end

    assign o_x     = qx_s[COORD_W-1:0];
    assign o_y     = qy_s[COORD_W-1:0];
    assign o_count = r_den;
    assign o_last  = r_phase_post || !r_cmd.post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (start_div || start_cordic) begin
                r_step <= '0;
            end else if (r_state == ST_DIV || r_state == ST_CORDIC) begin
                r_step <= r_step + 1'b1;
            end
            if (start_div) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else if (r_state == ST_ACC) begin
                r_sum_x <= r_sum_x + SW'(pxr);
                r_sum_y <= r_sum_y + SW'(pyr);
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (start_div) begin
            r_phase_post <= !(r_state == ST_IDLE && i_cmd.pre);
            r_negx <= r_sum_x[SW-1];
            r_negy <= r_sum_y[SW-1];
            r_qx   <= r_sum_x[SW-1] ? SW'(-r_sum_x) : SW'(r_sum_x);
            r_qy   <= r_sum_y[SW-1] ? SW'(-r_sum_y) : SW'(r_sum_y);
            r_rx   <= '0;
            r_ry   <= '0;
            r_den  <= r_count;
        end else if (r_state == ST_DIV) begin
            r_rx <= gex ? CW'(tx - {1'b0, r_den}) : tx[CW-1:0];
            r_ry <= gey ? CW'(ty - {1'b0, r_den}) : ty[CW-1:0];
            r_qx <= {r_qx[SW-2:0], gex};
            r_qy <= {r_qy[SW-2:0], gey};
        end
        if (start_cordic) begin
            r_flip <= src.angle[15] ^ src.angle[14];
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= XW'(signed'(a_turn));
        end else if (r_state == ST_CORDIC) begin
            r_cx <= nx;
            r_cy <= ny;
            r_cz <= nz;
        end
        if (r_state == ST_TRIG) begin
            r_cos <= COORD_W'(xr);
            r_sin <= COORD_W'(yr);
        end
        if (r_state == ST_MUL) begin
            r_px <= signed'({1'b0, r_cmd.range}) * r_cos;
            r_py <= signed'({1'b0, r_cmd.range}) * r_sin;
        end
    end

endmodule

// ===== design/range_scan_cluster_centroids_core.sv =====
// Top level of the laser scan jump-distance clustering core.
// Usage: range samples are written into the input queue (push, full) in scan
// order, one word per sample, with last_sample set on the final sample of a scan.
// Each word carries range_mm and an infinite flag. Cluster centroids come out of
// the result queue (empty, pop) as words of centroid_x, centroid_y, point_count
// and last_of_run, which marks the final result caused by one sample.
// A front end classifies each sample in its accept cycle and queues up to four
// commands, so input is taken while the back end works. For each kept point the
// back end runs a 24-step CORDIC, then rounding, multiply, accumulate and a
// hand-off state; for each centroid it runs a bit-serial divider of sum width,
// 28 steps at the default, then an emit state. A closing command is taken from
// an idle state. The back end finishes each command before it takes the next.
// The user must write registers over the APB port only while the core is idle;
// the core itself does not enforce this.
// Reset is synchronous and returns registers to their defaults and empties both
// queues and the open cluster. When the receiver stalls the result queue fills,
// the back end holds, and then the input queue reports full.
module range_scan_cluster_centroids_core #(
    parameter int SCAN_MAX = rscc_pkg::SCAN_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [15:0]                  i_range_mm,
    input  logic                         i_range_infinite,
    input  logic                         i_last_sample,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [rscc_pkg::COORD_W-1:0] o_centroid_x,
    output logic signed [rscc_pkg::COORD_W-1:0] o_centroid_y,
    output logic [$clog2(SCAN_MAX):0]    o_point_count,
    output logic                         o_last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rscc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rscc_pkg::*;

    localparam int CW = $clog2(SCAN_MAX) + 1;
    localparam int RW = 2 * COORD_W + CW + 1;
    localparam int MW = $bits(t_cmd);

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             cfg_wr, accept;
    logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd             cmd_in, cmd_out;
    logic [MW-1:0]    cmd_out_bits;
    logic             res_push, res_full;
    logic [COORD_W-1:0] res_x, res_y;
    logic [CW-1:0]    res_count;
    logic             res_last;
    logic [RW-1:0]    res_out;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign accept  = push && !full;
    assign full    = cmd_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_mm      <= 16'd100;
            r_cfg.max_mm      <= 16'd30000;
            r_cfg.gap         <= 16'd500;
            r_cfg.arc         <= 8'd180;
            r_cfg.scan_len    <= 12'd720;
            r_cfg.angle_start <= -16'sd16384;
            r_cfg.angle_step  <= 16'd91;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_MM:      r_cfg.min_mm      <= pwdata[15:0];
                REG_MAX_MM:      r_cfg.max_mm      <= pwdata[15:0];
                REG_GAP:         r_cfg.gap         <= pwdata[15:0];
                REG_ARC:         r_cfg.arc         <= pwdata[7:0];
                REG_SCAN_LEN:    r_cfg.scan_len    <= pwdata[11:0];
                REG_ANGLE_START: r_cfg.angle_start <= signed'(pwdata[15:0]);
                REG_ANGLE_STEP:  r_cfg.angle_step  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_MM:      prdata = 32'(r_cfg.min_mm);
            REG_MAX_MM:      prdata = 32'(r_cfg.max_mm);
            REG_GAP:         prdata = 32'(r_cfg.gap);
            REG_ARC:         prdata = 32'(r_cfg.arc);
            REG_SCAN_LEN:    prdata = 32'(r_cfg.scan_len);
            REG_ANGLE_START: prdata = 32'(unsigned'(r_cfg.angle_start));
            REG_ANGLE_STEP:  prdata = 32'(r_cfg.angle_step);
            default:         prdata = 32'd0;
        endcase
    end

    rscc_front #(.SCAN_MAX(SCAN_MAX)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (accept),
        .i_range_mm      (i_range_mm),
        .i_range_infinite(i_range_infinite),
        .i_last_sample   (i_last_sample),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    rscc_fifo #(.WIDTH(MW), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_out_bits),
        .o_empty(cmd_empty)
    );

    assign cmd_out = t_cmd'(cmd_out_bits);

    rscc_back #(.SCAN_MAX(SCAN_MAX)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(cmd_empty),
        .i_cmd      (cmd_out),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_x        (res_x),
        .o_y        (res_y),
        .o_count    (res_count),
        .o_last     (res_last)
    );

    rscc_fifo #(.WIDTH(RW), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data ({res_x, res_y, res_count, res_last}),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_out),
        .o_empty(empty)
    );

    assign o_centroid_x  = signed'(res_out[RW-1 -: COORD_W]);
    assign o_centroid_y  = signed'(res_out[RW-1-COORD_W -: COORD_W]);
    assign o_point_count = res_out[CW:1];
    assign o_last_of_run = res_out[0];

endmodule

// ===== design/rscc_checker.sv =====
// Port-level checker for the scan clustering core, bound to the top level.
`include "range_scan_cluster_centroids_core_defines.svh"

module rscc_checker #(
    parameter int SCAN_MAX = rscc_pkg::SCAN_MAX_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         empty,
    input logic                         pready,
    input logic [rscc_pkg::COORD_W-1:0] o_centroid_x,
    input logic [rscc_pkg::COORD_W-1:0] o_centroid_y,
    input logic [$clog2(SCAN_MAX):0]    o_point_count
);
    import rscc_pkg::*;

    `RSCC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, empty)
    `RSCC_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, !empty, o_point_count != '0)
    `RSCC_ASSERT_NOW(a_x_in_range, i_clk, i_rst_n, !empty, o_centroid_x != 17'h10000)
    `RSCC_ASSERT_NOW(a_y_in_range, i_clk, i_rst_n, !empty, o_centroid_y != 17'h10000)
    `RSCC_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind range_scan_cluster_centroids_core rscc_checker #(.SCAN_MAX(SCAN_MAX)) u_rscc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pready       (pready),
    .o_centroid_x (o_centroid_x),
    .o_centroid_y (o_centroid_y),
    .o_point_count(o_point_count)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the laser scan jump-distance clustering core.
`timescale 1ns / 100ps

module testbench;
    import rscc_pkg::*;

    localparam int LIMIT    = 2_000_000;
    localparam int SETTLE   = 500;
    localparam int HOLD_OFF = 3000;

    typedef struct {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic [11:0]        count;
        logic               last;
    } centroid_t;

    class cluster_scoreboard;
        logic [15:0] rmin, rmax, gap, start, step;
        logic [7:0]  arc;
        logic [11:0] slen;
        int unsigned idx, prev_range, size;
        bit          prev_valid;
        longint      sx, sy;
        centroid_t   expected_q[$];
        int          errors;
        longint      atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

        function new();
            rmin = 100; rmax = 30000; gap = 500; arc = 180; slen = 720;
            start = 16'hC000; step = 91;
            idx = 0; prev_range = 0; prev_valid = 0; sx = 0; sy = 0; size = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx r, logic [15:0] v);
            case (r)
                REG_MIN_MM:      rmin = v;
                REG_MAX_MM:      rmax = v;
                REG_GAP:         gap = v;
                REG_ARC:         arc = v[7:0];
                REG_SCAN_LEN:    slen = v[11:0];
                REG_ANGLE_START: start = v;
                REG_ANGLE_STEP:  step = v;
                default: ;
            endcase
        endfunction

        function longint round15(longint v);
            return (v + (64'sd1 <<< 14)) >>> 15;
        endfunction

        function void cos_sin(logic [15:0] bau, output longint c, output longint s);
            logic [31:0] a;
            bit          flip;
            longint      x, y, z, nx;
            a = {bau, 16'h0000};
            flip = (bau[15:14] == 2'b01) || (bau[15:14] == 2'b10);
            if (flip) a = a - 32'h8000_0000;
            z = longint'($signed(a));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 24; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_tab[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_tab[i];
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            x = round15(x);
            y = round15(y);
            if (x > 32768) x = 32768;
            if (x < -32768) x = -32768;
            if (y > 32768) y = 32768;
            if (y < -32768) y = -32768;
            c = x;
            s = y;
        endfunction

        function bit in_window(int unsigned i);
            longint m, lhs, len;
            m = (180 - longint'(arc)) / 2;
            lhs = 180 * longint'(i);
            len = longint'(slen);
            return lhs > len * m && lhs < len * (180 - m);
        endfunction

        function void close_cluster(ref centroid_t fresh[$]);
            centroid_t e;
            longint    mx, my;
            if (size == 0) return;
            mx = sx / longint'(size);
            my = sy / longint'(size);
            e.cx = mx[16:0];
            e.cy = my[16:0];
            e.count = size[11:0];
            e.last = 0;
            fresh = {fresh, e};
            sx = 0;
            sy = 0;
            size = 0;
        endfunction

        function void note_sample(logic [15:0] r, bit inf, bit last);
            centroid_t   fresh[$];
            bit          valid, join_ok;
            int unsigned diff;
            longint      c, s;
            logic [15:0] ang;
            valid = !inf && r > rmin && r < rmax;
            if (idx != 0) begin
                if (valid && in_window(idx)) begin
                    diff = (r > prev_range) ? r - prev_range : prev_range - r;
                    join_ok = (!prev_valid || diff < gap) && size < 2048;
                    if (!join_ok) close_cluster(fresh);
                    ang = start + step * idx[15:0];
                    cos_sin(ang, c, s);
                    sx += round15(longint'(r) * c);
                    sy += round15(longint'(r) * s);
                    size++;
                end else begin
                    close_cluster(fresh);
                end
            end
            if (last) begin
                close_cluster(fresh);
                idx = 0;
            end else if (idx < 2047) begin
                idx++;
            end
            prev_range = r;
            prev_valid = valid;
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1;
            foreach (fresh[k]) expected_q = {expected_q, fresh[k]};
        endfunction

        task report(string what);
            $display("centroid word mismatch: %s", what);
            errors++;
        endtask

        task check_result(centroid_t got);
            centroid_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word x=%0d y=%0d n=%0d", got.cx, got.cy,
                    got.count));
                return;
            end
            e = expected_q.pop_front();
            if (got.cx !== e.cx) report($sformatf("x %0d, want %0d", got.cx, e.cx));
            if (got.cy !== e.cy) report($sformatf("y %0d, want %0d", got.cy, e.cy));
            if (got.count !== e.count)
                report($sformatf("count %0d, want %0d", got.count, e.count));
            if (got.last !== e.last) report($sformatf("last %0b, want %0b", got.last, e.last));
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               full;
    logic [15:0]        i_range_mm = 0;
    logic               i_range_infinite = 0;
    logic               i_last_sample = 0;
    logic               empty;
    logic               pop = 0;
    logic signed [16:0] o_centroid_x, o_centroid_y;
    logic [11:0]        o_point_count;
    logic               o_last_of_run;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0]  paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    cluster_scoreboard sb = new();
    bit busy = 1;
    bit hold_off = 0;
    bit outstanding_late = 0;

    range_scan_cluster_centroids_core dut (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("range_scan_cluster_centroids_core: mismatch");
        $finish;
    end

    initial begin
        centroid_t got;
        int        gap_left;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.cx = o_centroid_x;
                got.cy = o_centroid_y;
                got.count = o_point_count;
                got.last = o_last_of_run;
                sb.check_result(got);
                gap_left = busy ? $urandom_range(0, 6) : 0;
            end
            if (hold_off || gap_left > 0) begin
                pop <= 0;
                if (!hold_off) gap_left--;
            end else begin
                pop <= 1;
            end
        end
    end

    task write_reg(t_reg_idx r, logic [15:0] v);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= {16'h0000, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(r, v);
    endtask

    task send_sample(logic [15:0] r, bit inf, bit last);
        int wait_n;
        wait_n = busy ? $urandom_range(0, 6) : 0;
        if (wait_n > 0) begin
            push <= 0;
            repeat (wait_n) @(posedge i_clk);
        end
        push <= 1;
        i_range_mm <= r;
        i_range_infinite <= inf;
        i_last_sample <= last;
        do @(posedge i_clk); while (full);
        sb.note_sample(r, inf, last);
    endtask

    task drain;
        push <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task random_scans(int n_items);
        int          count, len;
        logic [15:0] r;
        count = 0;
        while (count < n_items) begin
            len = $urandom_range(2, int'(sb.slen) + 4);
            r = 16'($urandom);
            for (int k = 0; k < len && count < n_items; k++) begin
                case ($urandom_range(0, 9))
                    0: send_sample(16'($urandom), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
                    1: send_sample(16'($urandom), 1, k == len - 1);
                    2: begin
                        r = 16'($urandom_range(sb.rmin, sb.rmax));
                        send_sample(r, 0, k == len - 1);
                    end
                    default: begin
                        r = r + 16'($signed($urandom_range(0, 2 * sb.gap + 2)) - sb.gap - 1);
                        if ($urandom_range(0, 5) == 0) r = 16'($urandom_range(sb.rmin, sb.rmax));
                        send_sample(r, 0, k == len - 1);
                    end
                endcase
                count++;
            end
        end
    endtask

    task set_all(logic [15:0] mn, logic [15:0] mx, logic [15:0] g, logic [7:0] a,
                 logic [11:0] l, logic [15:0] st, logic [15:0] sp);
        write_reg(REG_MIN_MM, mn);
        write_reg(REG_MAX_MM, mx);
        write_reg(REG_GAP, g);
        write_reg(REG_ARC, 16'(a));
        write_reg(REG_SCAN_LEN, 16'(l));
        write_reg(REG_ANGLE_START, st);
        write_reg(REG_ANGLE_STEP, sp);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        busy = 0;
        send_sample(5000, 0, 0);
        send_sample(5100, 0, 0);
        send_sample(5599, 0, 0);
        send_sample(6099, 0, 0);
        send_sample(100, 0, 0);
        send_sample(101, 0, 0);
        send_sample(29999, 0, 0);
        send_sample(30000, 0, 0);
        send_sample(0, 1, 0);
        send_sample(65535, 0, 0);
        send_sample(2000, 0, 0);
        send_sample(2000, 1, 0);
        send_sample(2100, 0, 0);
        send_sample(9000, 0, 1);
        send_sample(0, 1, 1);
        send_sample(3000, 0, 0);
        send_sample(3001, 0, 1);
        busy = 1;
        drain();

        set_all(0, 65535, 0, 0, 2, 16'h8000, 0);
        random_scans(100);
        drain();
        set_all(0, 65535, 65535, 180, 2047, 16'h7FFF, 16'hFFFF);
        random_scans(100);
        drain();

        fork
            begin
                hold_off <= 1;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_off <= 0;
            end
        join_none
        for (int p = 0; p < 7; p++) begin
            busy = (p % 3) != 1;
            set_all(16'($urandom_range(0, 2000)), 16'($urandom_range(20000, 65535)),
                16'($urandom_range(50, 3000)), 8'($urandom_range(0, 180)),
                12'($urandom_range(8, 64)), 16'($urandom), 16'($urandom));
            random_scans(120);
            drain();
        end

        busy = 0;
        set_all(0, 65535, 65535, 255, 2047, 0, 37);
        for (int k = 0; k < 600; k++) send_sample(1000, 0, 0);
        send_sample(1000, 0, 1);
        drain();

        if (sb.errors == 0)
            $display("range_scan_cluster_centroids_core: match");
        else
            $display("range_scan_cluster_centroids_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/rscc_pkg.sv
design/rscc_fifo.sv
design/rscc_front.sv
design/rscc_back.sv
design/range_scan_cluster_centroids_core.sv
design/rscc_checker.sv
dv/testbench.sv
